>>> design/orbcam_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the orbit camera block.
// Used by orbcam_cordic, orbcam_smul and orbit_camera_position; depends on nothing else.

package orbcam_pkg;

   // Field widths of the camera state and the configuration port.
   localparam int unsigned AZ_W       = 15;
   localparam int unsigned ELEV_W     = 13;
   localparam int unsigned RAD_W      = 15;
   localparam int unsigned CSR_DATA_W = 15;
   localparam int unsigned CSR_IDX_W  = 2;

   // Angles are held in 1/64 degree.
   localparam int FULL_TURN    = 23040;
   localparam int HALF_TURN    = 11520;
   localparam int QUARTER_TURN = 5760;

   // Reset values of the configuration registers and the camera state.
   localparam logic [ELEV_W-1:0] MIN_ELEV_RESET = 13'd320;
   localparam logic [ELEV_W-1:0] MAX_ELEV_RESET = 13'd5440;
   localparam logic [RAD_W-1:0]  MIN_RAD_RESET  = 15'd256;
   localparam logic [RAD_W-1:0]  MAX_RAD_RESET  = 15'd25600;
   localparam logic [AZ_W-1:0]   AZ_RESET       = 15'd0;
   localparam logic [ELEV_W-1:0] ELEV_RESET     = 13'd2880;
   localparam logic [RAD_W-1:0]  RAD_RESET      = 15'd2560;

   // Command codes.
   localparam logic [1:0] CMD_AZIMUTH   = 2'd0;
   localparam logic [1:0] CMD_ELEVATION = 2'd1;
   localparam logic [1:0] CMD_ZOOM      = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ELEV = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ELEV = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RAD  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RAD  = 2'd3;

   // CORDIC: vector in Q2.30 with headroom, angle in degrees times 2^16.
   localparam int unsigned TRIG_W       = 32;
   localparam int unsigned CORDIC_W     = 34;
   localparam int unsigned ANGLE_W      = 25;
   localparam int unsigned STEP_W       = 5;
   localparam int unsigned ATAN_ENTRIES = 24;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

   // Serial multiplier: full 32-bit multiplier word or a short 16-bit one for the radius.
   localparam int unsigned MUL_W     = 32;
   localparam int unsigned MUL_CNT_W = 5;
   localparam int unsigned SHORT_LEN = 16;
   localparam int unsigned PROD_W    = 64;
   localparam int unsigned ROUND_W   = 34;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [15:0] amount;
   } req_type;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic short_len;
   } mul_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AZ_RUN,
      ST_EL_RUN,
      ST_MUL_XA,
      ST_MUL_ZA,
      ST_MUL_X,
      ST_MUL_Y,
      ST_MUL_Z,
      ST_FINISH
   } state_type;

   // atan(2^-i) in degrees times 2^16, rounded to nearest.
   function automatic logic signed [ANGLE_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
      logic signed [ANGLE_W-1:0] val;
      case (idx)
         5'd0:    val = 25'sd2949120;
         5'd1:    val = 25'sd1740967;
         5'd2:    val = 25'sd919879;
         5'd3:    val = 25'sd466945;
         5'd4:    val = 25'sd234379;
         5'd5:    val = 25'sd117304;
         5'd6:    val = 25'sd58666;
         5'd7:    val = 25'sd29335;
         5'd8:    val = 25'sd14668;
         5'd9:    val = 25'sd7334;
         5'd10:   val = 25'sd3667;
         5'd11:   val = 25'sd1833;
         5'd12:   val = 25'sd917;
         5'd13:   val = 25'sd458;
         5'd14:   val = 25'sd229;
         5'd15:   val = 25'sd115;
         5'd16:   val = 25'sd57;
         5'd17:   val = 25'sd29;
         5'd18:   val = 25'sd14;
         5'd19:   val = 25'sd7;
         5'd20:   val = 25'sd4;
         5'd21:   val = 25'sd2;
         5'd22:   val = 25'sd1;
         default: val = 25'sd0;
      endcase
      return val;
   endfunction

endpackage

>>> design/orbcam_cordic.sv
// Iterative rotation-mode CORDIC giving sine and cosine of an angle in 1/64 degree.
// Depends on orbcam_pkg for widths, the gain constant and the arctangent table.

module orbcam_cordic #(
   parameter int unsigned STEPS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [orbcam_pkg::AZ_W-1:0]            angle,
   output logic                                   done,
   output logic signed [orbcam_pkg::TRIG_W-1:0]   sin_q30,
   output logic signed [orbcam_pkg::TRIG_W-1:0]   cos_q30
);

   localparam int unsigned CW = orbcam_pkg::CORDIC_W;
   localparam int unsigned AW = orbcam_pkg::ANGLE_W;
   localparam int unsigned SW = orbcam_pkg::STEP_W;

   localparam logic signed [15:0] FULL    = 16'(orbcam_pkg::FULL_TURN);
   localparam logic signed [15:0] HALF    = 16'(orbcam_pkg::HALF_TURN);
   localparam logic signed [15:0] QUARTER = 16'(orbcam_pkg::QUARTER_TURN);
   localparam logic [SW-1:0] LAST_STEP = SW'(STEPS - 1);
   localparam logic [SW-1:0] STEP_ONE  = SW'(1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 flip_ff, flip_in;
   logic [SW-1:0]        k_ff, k_in;
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [AW-1:0] z_ff, z_in;

   logic signed [15:0]   ang_s, ang_fold;
   logic                 fold;
   logic signed [AW-1:0] z_start, atan_k;
   logic signed [CW-1:0] x_sh, y_sh, x_neg;

   // Fold the angle into -90..90 degrees; the cosine changes sign where it is mirrored.
   always_comb begin
      ang_s = $signed({1'b0, angle});
      if (ang_s >= HALF) begin
         ang_s = ang_s - FULL;
      end
      fold     = 1'b0;
      ang_fold = ang_s;
      if (ang_s > QUARTER) begin
         ang_fold = HALF - ang_s;
         fold     = 1'b1;
      end else if (ang_s < -QUARTER) begin
         ang_fold = -HALF - ang_s;
         fold     = 1'b1;
      end
      z_start = $signed({ang_fold[14:0], 10'b0});
   end

   always_comb begin
      x_sh   = x_ff >>> k_ff;
      y_sh   = y_ff >>> k_ff;
      atan_k = orbcam_pkg::atan_entry(k_ff);

      busy_in = busy_ff;
      done_in = 1'b0;
      flip_in = flip_ff;
      k_in    = k_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;

      if (start) begin
         busy_in = 1'b1;
         flip_in = fold;
         k_in    = '0;
         x_in    = orbcam_pkg::CORDIC_GAIN;
         y_in    = '0;
         z_in    = z_start;
      end else if (busy_ff) begin
         if (!z_ff[AW-1]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - atan_k;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + atan_k;
         end
         k_in = k_ff + STEP_ONE;
         if (k_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      flip_ff <= flip_in;
      k_ff    <= k_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign x_neg   = -x_ff;
   assign done    = done_ff;
   assign sin_q30 = $signed(y_ff[orbcam_pkg::TRIG_W-1:0]);
   assign cos_q30 = flip_ff ? $signed(x_neg[orbcam_pkg::TRIG_W-1:0])
                            : $signed(x_ff[orbcam_pkg::TRIG_W-1:0]);

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("CORDIC started while a rotation is still running");

endmodule

>>> design/orbcam_smul.sv
// Bit-serial signed shift-and-add multiplier with Q30 round-half-up on its result.
// Depends on orbcam_pkg for widths and the command struct.

module orbcam_smul (
   input  logic                                    clock,
   input  logic                                    reset,
   input  orbcam_pkg::mul_cmd_type                 cmd,
   input  logic signed [orbcam_pkg::MUL_W-1:0]     mcand,
   input  logic signed [orbcam_pkg::MUL_W-1:0]     mplier,
   output logic                                    done,
   output logic signed [orbcam_pkg::ROUND_W-1:0]   result
);

   localparam int unsigned W   = orbcam_pkg::MUL_W;
   localparam int unsigned CNW = orbcam_pkg::MUL_CNT_W;
   localparam int unsigned SL  = orbcam_pkg::SHORT_LEN;
   localparam int unsigned PW  = orbcam_pkg::PROD_W;
   localparam int unsigned SHORT_FILL = PW - (W + 1) - SL;
   localparam logic [CNW-1:0] FULL_LAST  = CNW'(W - 1);
   localparam logic [CNW-1:0] SHORT_LAST = CNW'(SL - 1);
   localparam logic [CNW-1:0] CNT_ONE    = CNW'(1);
   localparam logic signed [PW-1:0] ROUND_HALF = PW'(64'sd536870912);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  short_ff, short_in;
   logic [CNW-1:0]        cnt_ff, cnt_in;
   logic signed [W-1:0]   mcand_ff, mcand_in;
   logic signed [W:0]     hi_ff, hi_in;
   logic [W-1:0]          lo_ff, lo_in;

   logic                  last;
   logic signed [W+1:0]   hi_ext, add_ext, psum;
   logic signed [PW-1:0]  prod, rsum;

   // One multiplier bit a cycle: the partial sum sits in hi, the used multiplier bits leave lo
   // from the bottom while the low product bits enter it from the top.
   always_comb begin
      last    = (cnt_ff == (short_ff ? SHORT_LAST : FULL_LAST));
      hi_ext  = {hi_ff[W], hi_ff};
      add_ext = {{2{mcand_ff[W-1]}}, mcand_ff};
      if (lo_ff[0]) begin
         psum = last ? (hi_ext - add_ext) : (hi_ext + add_ext);
      end else begin
         psum = hi_ext;
      end

      busy_in  = busy_ff;
      done_in  = 1'b0;
      short_in = short_ff;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;

      if (cmd.start) begin
         busy_in  = 1'b1;
         short_in = cmd.short_len;
         cnt_in   = '0;
         mcand_in = mcand;
         hi_in    = '0;
         lo_in    = mplier;
      end else if (busy_ff) begin
         hi_in  = psum[W+1:1];
         lo_in  = {psum[0], lo_ff[W-1:1]};
         cnt_in = cnt_ff + CNT_ONE;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      short_ff <= short_in;
      cnt_ff   <= cnt_in;
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
   end

   always_comb begin
      if (short_ff) begin
         prod = $signed({{SHORT_FILL{hi_ff[W]}}, hi_ff, lo_ff[W-1 -: SL]});
      end else begin
         prod = $signed({hi_ff[W-1:0], lo_ff});
      end
      rsum = prod + ROUND_HALF;
   end

   assign done   = done_ff;
   assign result = $signed(rsum[PW-1 -: orbcam_pkg::ROUND_W]);

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("Multiplier started while a product is still being formed");

endmodule

>>> design/orbit_camera_position.sv
// Top level of the orbit camera: camera state, configuration registers and the sequencer
// that drives one CORDIC and one bit-serial multiplier. Depends on orbcam_pkg,
// orbcam_cordic and orbcam_smul.
//
// The block holds an orbit camera's azimuth, elevation and radius. Each request transaction
// carries a command (rotate azimuth, rotate elevation, zoom; the fourth code leaves the state
// alone) and a signed amount, and produces exactly one response transaction with the camera
// position x = r sin(az) cos(el), y = r sin(el), z = r cos(az) cos(el) in signed Q7.8,
// saturated to 16 bits. Azimuth wraps at 360 degrees; elevation and radius are clamped to the
// configured limits, minimum first and maximum second, so crossed limits give the maximum.
// One transaction at a time is processed: the CORDIC runs twice (azimuth, then elevation),
// and the shift-and-add multiplier forms five products one multiplier bit per cycle, two
// with a 32-bit multiplier and three with the 16-bit radius. A new request is taken only
// once the response of the previous one has been loaded into the output register.
// The response sits in an output register, so a new request is accepted while the previous
// response still waits to be taken. Configuration writes are always taken (csr_ready is held
// high) and must only be made while the block is idle.

module orbit_camera_position #(
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  orbcam_pkg::req_type                      req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output orbcam_pkg::rsp_type                      rsp_data,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [orbcam_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [orbcam_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int unsigned AZ_W   = orbcam_pkg::AZ_W;
   localparam int unsigned ELEV_W = orbcam_pkg::ELEV_W;
   localparam int unsigned RAD_W  = orbcam_pkg::RAD_W;
   localparam int unsigned TW     = orbcam_pkg::TRIG_W;
   localparam int unsigned RW     = orbcam_pkg::ROUND_W;
   localparam int unsigned MW     = orbcam_pkg::MUL_W;

   localparam logic signed [16:0] AZ_TURN      = 17'(orbcam_pkg::FULL_TURN);
   localparam logic signed [16:0] AZ_TWO_TURNS = 17'(2 * orbcam_pkg::FULL_TURN);
   localparam logic [AZ_W-1:0]    AZ_LIMIT     = AZ_W'(orbcam_pkg::FULL_TURN);
   localparam logic signed [RW-1:0] POS_MAX    = RW'(32767);
   localparam logic signed [RW-1:0] NEG_MIN    = -RW'(32768);

   // Saturate a rounded Q7.8 value to the 16-bit output range.
   function automatic logic signed [15:0] sat16(input logic signed [RW-1:0] v);
      logic signed [15:0] r;
      if (v > POS_MAX) begin
         r = 16'sh7FFF;
      end else if (v < NEG_MIN) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   orbcam_pkg::state_type state_ff, state_in;
   logic launch_ff, launch_in;
   logic rsp_full_ff, rsp_full_in;
   logic rsp_load;
   logic req_accept;

   // Configuration registers.
   logic [ELEV_W-1:0] min_elev_ff, max_elev_ff;
   logic [RAD_W-1:0]  min_rad_ff, max_rad_ff;

   // Camera state.
   logic [AZ_W-1:0]   az_ff, az_in;
   logic [ELEV_W-1:0] elev_ff, elev_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;

   // Intermediate results of one transaction.
   logic signed [TW-1:0] sa_ff, ca_ff, se_ff, ce_ff, tx_ff, tz_ff;
   logic signed [15:0]   px_ff, py_ff, pz_ff;
   orbcam_pkg::rsp_type  rsp_data_ff;

   // Shared units.
   logic                    cor_start, cor_done;
   logic [AZ_W-1:0]         cor_angle;
   logic signed [TW-1:0]    cor_sin, cor_cos;
   orbcam_pkg::mul_cmd_type mul_cmd;
   logic signed [MW-1:0]    mul_mcand, mul_mplier, rad_word;
   logic                    mul_done;
   logic signed [RW-1:0]    mul_result;

   logic signed [16:0] az_sum, az_fix;
   logic signed [17:0] el_sum, rad_sum, amt_ext;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != orbcam_pkg::ST_IDLE);
   assign rsp_valid  = rsp_full_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // Apply the command of a newly accepted transaction to the camera state.
   always_comb begin
      amt_ext = {{2{req_data.amount[15]}}, req_data.amount};

      az_sum = $signed({2'b00, az_ff}) + $signed({req_data.amount[15], req_data.amount});
      if (az_sum < -AZ_TURN) begin
         az_fix = az_sum + AZ_TWO_TURNS;
      end else if (az_sum < 17'sd0) begin
         az_fix = az_sum + AZ_TURN;
      end else if (az_sum >= AZ_TWO_TURNS) begin
         az_fix = az_sum - AZ_TWO_TURNS;
      end else if (az_sum >= AZ_TURN) begin
         az_fix = az_sum - AZ_TURN;
      end else begin
         az_fix = az_sum;
      end

      el_sum = $signed({5'b0, elev_ff}) + amt_ext;
      if (el_sum < $signed({5'b0, min_elev_ff})) begin
         el_sum = $signed({5'b0, min_elev_ff});
      end
      if (el_sum > $signed({5'b0, max_elev_ff})) begin
         el_sum = $signed({5'b0, max_elev_ff});
      end

      rad_sum = $signed({3'b0, rad_ff}) + amt_ext;
      if (rad_sum < $signed({3'b0, min_rad_ff})) begin
         rad_sum = $signed({3'b0, min_rad_ff});
      end
      if (rad_sum > $signed({3'b0, max_rad_ff})) begin
         rad_sum = $signed({3'b0, max_rad_ff});
      end

      az_in   = az_ff;
      elev_in = elev_ff;
      rad_in  = rad_ff;
      if (req_accept) begin
         case (req_data.command)
            orbcam_pkg::CMD_AZIMUTH: begin
               az_in = az_fix[AZ_W-1:0];
            end
            orbcam_pkg::CMD_ELEVATION: begin
               elev_in = el_sum[ELEV_W-1:0];
            end
            orbcam_pkg::CMD_ZOOM: begin
               rad_in = rad_sum[RAD_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Sequencer: each unit is started by a one-cycle launch on entry to its state and the
   // sequencer moves on when that unit reports done.
   always_comb begin
      state_in  = state_ff;
      launch_in = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         orbcam_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in  = orbcam_pkg::ST_AZ_RUN;
               launch_in = 1'b1;
            end
         end
         orbcam_pkg::ST_AZ_RUN: begin
            if (cor_done) begin
               state_in  = orbcam_pkg::ST_EL_RUN;
               launch_in = 1'b1;
            end
         end
         orbcam_pkg::ST_EL_RUN: begin
            if (cor_done) begin
               state_in  = orbcam_pkg::ST_MUL_XA;
               launch_in = 1'b1;
            end
         end
         orbcam_pkg::ST_MUL_XA: begin
            if (mul_done) begin
               state_in  = orbcam_pkg::ST_MUL_ZA;
               launch_in = 1'b1;
            end
         end
         orbcam_pkg::ST_MUL_ZA: begin
            if (mul_done) begin
               state_in  = orbcam_pkg::ST_MUL_X;
               launch_in = 1'b1;
            end
         end
         orbcam_pkg::ST_MUL_X: begin
            if (mul_done) begin
               state_in  = orbcam_pkg::ST_MUL_Y;
               launch_in = 1'b1;
            end
         end
         orbcam_pkg::ST_MUL_Y: begin
            if (mul_done) begin
               state_in  = orbcam_pkg::ST_MUL_Z;
               launch_in = 1'b1;
            end
         end
         orbcam_pkg::ST_MUL_Z: begin
            if (mul_done) begin
               state_in = orbcam_pkg::ST_FINISH;
            end
         end
         orbcam_pkg::ST_FINISH: begin
            // Wait here only while an earlier response is still held by the receiver.
            if (!rsp_full_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = orbcam_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = orbcam_pkg::ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_full_in = 1'b1;
      end else begin
         rsp_full_in = rsp_full_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= orbcam_pkg::ST_IDLE;
         launch_ff   <= 1'b0;
         rsp_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         launch_ff   <= launch_in;
         rsp_full_ff <= rsp_full_in;
      end
   end

   // Configuration registers and camera state.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_elev_ff <= orbcam_pkg::MIN_ELEV_RESET;
         max_elev_ff <= orbcam_pkg::MAX_ELEV_RESET;
         min_rad_ff  <= orbcam_pkg::MIN_RAD_RESET;
         max_rad_ff  <= orbcam_pkg::MAX_RAD_RESET;
         az_ff       <= orbcam_pkg::AZ_RESET;
         elev_ff     <= orbcam_pkg::ELEV_RESET;
         rad_ff      <= orbcam_pkg::RAD_RESET;
      end else begin
         az_ff   <= az_in;
         elev_ff <= elev_in;
         rad_ff  <= rad_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               orbcam_pkg::CSR_MIN_ELEV: min_elev_ff <= csr_data[ELEV_W-1:0];
               orbcam_pkg::CSR_MAX_ELEV: max_elev_ff <= csr_data[ELEV_W-1:0];
               orbcam_pkg::CSR_MIN_RAD:  min_rad_ff  <= csr_data[RAD_W-1:0];
               orbcam_pkg::CSR_MAX_RAD:  max_rad_ff  <= csr_data[RAD_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Operand selection for the shared units, fixed for the whole of each state.
   assign rad_word  = $signed({{(MW - RAD_W){1'b0}}, rad_ff});
   assign cor_start = launch_ff && (state_ff == orbcam_pkg::ST_AZ_RUN ||
                                    state_ff == orbcam_pkg::ST_EL_RUN);

   always_comb begin
      case (state_ff)
         orbcam_pkg::ST_EL_RUN: cor_angle = {{(AZ_W - ELEV_W){1'b0}}, elev_ff};
         default:               cor_angle = az_ff;
      endcase

      mul_cmd.start     = launch_ff && !cor_start && (state_ff != orbcam_pkg::ST_IDLE);
      mul_cmd.short_len = 1'b1;
      case (state_ff)
         orbcam_pkg::ST_MUL_XA: begin
            mul_mcand         = sa_ff;
            mul_mplier        = ce_ff;
            mul_cmd.short_len = 1'b0;
         end
         orbcam_pkg::ST_MUL_ZA: begin
            mul_mcand         = ca_ff;
            mul_mplier        = ce_ff;
            mul_cmd.short_len = 1'b0;
         end
         orbcam_pkg::ST_MUL_Y: begin
            mul_mcand  = se_ff;
            mul_mplier = rad_word;
         end
         orbcam_pkg::ST_MUL_Z: begin
            mul_mcand  = tz_ff;
            mul_mplier = rad_word;
         end
         default: begin
            mul_mcand  = tx_ff;
            mul_mplier = rad_word;
         end
      endcase
   end

   orbcam_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (cor_angle),
      .done    (cor_done),
      .sin_q30 (cor_sin),
      .cos_q30 (cor_cos)
   );

   orbcam_smul u_smul (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mul_cmd),
      .mcand  (mul_mcand),
      .mplier (mul_mplier),
      .done   (mul_done),
      .result (mul_result)
   );

   // Capture each partial result as its unit finishes.
   always_ff @(posedge clock) begin
      if (cor_done && state_ff == orbcam_pkg::ST_AZ_RUN) begin
         sa_ff <= cor_sin;
         ca_ff <= cor_cos;
      end
      if (cor_done && state_ff == orbcam_pkg::ST_EL_RUN) begin
         se_ff <= cor_sin;
         ce_ff <= cor_cos;
      end
      if (mul_done) begin
         case (state_ff)
            orbcam_pkg::ST_MUL_XA: tx_ff <= mul_result[TW-1:0];
            orbcam_pkg::ST_MUL_ZA: tz_ff <= mul_result[TW-1:0];
            orbcam_pkg::ST_MUL_X:  px_ff <= sat16(mul_result);
            orbcam_pkg::ST_MUL_Y:  py_ff <= sat16(mul_result);
            orbcam_pkg::ST_MUL_Z:  pz_ff <= sat16(mul_result);
            default: begin
            end
         endcase
      end
      if (rsp_load) begin
         rsp_data_ff.pos_x <= px_ff;
         rsp_data_ff.pos_y <= py_ff;
         rsp_data_ff.pos_z <= pz_ff;
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("Request taken but the block did not become busy");

   a_azimuth_range: assert property (@(posedge clock) disable iff (reset)
      az_ff < AZ_LIMIT)
      else $error("Azimuth left the range of one full turn");

   a_cordic_done_state: assert property (@(posedge clock) disable iff (reset)
      cor_done |-> (state_ff == orbcam_pkg::ST_AZ_RUN || state_ff == orbcam_pkg::ST_EL_RUN))
      else $error("CORDIC finished outside a rotation state");

   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == orbcam_pkg::ST_MUL_XA || state_ff == orbcam_pkg::ST_MUL_ZA ||
                    state_ff == orbcam_pkg::ST_MUL_X || state_ff == orbcam_pkg::ST_MUL_Y ||
                    state_ff == orbcam_pkg::ST_MUL_Z))
      else $error("Multiplier finished outside a product state");

endmodule
